### hdl/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
// No dependencies; imported by the controller, datapath and top level.
package bpa_pkg;

    localparam int NUM_FRAMES = 4096;
    localparam int NUM_ORDERS = 11;
    localparam int FRAME_W    = 12;
    localparam int LINK_W     = 13;
    localparam int ORD_W      = 4;
    localparam int ZONE_RESET = 4096;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_FRAMES);

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_NOFREE = 2'd1;
    localparam logic [1:0] STS_ORDER  = 2'd2;
    localparam logic [1:0] STS_FRAME  = 2'd3;

    // datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_CLR       = 4'd1;
    localparam logic [3:0] OP_LOAD      = 4'd2;
    localparam logic [3:0] OP_NEXT      = 4'd3;
    localparam logic [3:0] OP_SEL_POP   = 4'd4;
    localparam logic [3:0] OP_SEL_SPLIT = 4'd5;
    localparam logic [3:0] OP_SEL_PUSHF = 4'd6;
    localparam logic [3:0] OP_ULNK_RD   = 4'd7;
    localparam logic [3:0] OP_ULNK_WR   = 4'd8;
    localparam logic [3:0] OP_PUSH0     = 4'd9;
    localparam logic [3:0] OP_PUSH1     = 4'd10;
    localparam logic [3:0] OP_MARK_RD   = 4'd11;
    localparam logic [3:0] OP_BUD_RD    = 4'd12;
    localparam logic [3:0] OP_MERGE     = 4'd13;
    localparam logic [3:0] OP_OUT       = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic       res;
        logic [1:0] res_sts;
        logic       res_grant;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic head_empty;
        logic cur_top;
        logic cur_eq_ord;
        logic ord_bad;
        logic frm_bad;
        logic cmd_free;
        logic mark_q;
        logic ord_match;
        logic ord_top;
        logic bud_out;
        logic push_ok;
        logic out_busy;
    } t_sts;

endpackage

### hdl/buddy_page_allocator_top.sv
// Top level of the buddy page allocator: stream ports, zone register, units.
// Depends on bpa_pkg, bpa_ctrl and bpa_dp.
//
//  channel  | direction | handshake              | contents
//  s stream | in        | i_s_tvalid/o_s_tready  | tuser command, tdata order, frame
//  m stream | out       | o_m_tvalid/i_m_tready  | tdata status, granted frame, total
//  apb      | in        | psel/penable/pready    | zone_frames at byte address 0
//
// One word at a time. Allocate time is set by the order search and the push per
// split; free time is set by the merge loop's memory reads. After reset a
// clearing pass over all 4096 frames zeroes the free marks; no word is taken
// meanwhile. A finished word waits in the output register while a new word is
// accepted.
module buddy_page_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic        i_s_tuser,  // [0] command
    input  logic [15:0] i_s_tdata,  // [3:0] block_order, [15:4] frame_index
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [1:0] status, [13:2] granted_frame,
                                    // [26:14] free_total, [31:27] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bpa_pkg::*;

    localparam logic ADDR_ZONE = 1'b0;

    logic [LINK_W-1:0]  r_zone;
    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [1:0]         w_status;
    logic [FRAME_W-1:0] w_grant;
    logic [LINK_W-1:0]  w_free;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_ZONE) ? {19'd0, r_zone} : 32'd0;

    // zone register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= LINK_W'(ZONE_RESET);
        end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_ZONE) begin
            r_zone <= pwdata[LINK_W-1:0];
        end
    end

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bpa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_zone     (r_zone),
        .i_in_cmd   (i_s_tuser),
        .i_in_ord   (i_s_tdata[3:0]),
        .i_in_frm   (i_s_tdata[15:4]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_status   (w_status),
        .o_grant    (w_grant),
        .o_free     (w_free)
    );

    assign o_m_tdata = {5'd0, w_free, w_grant, w_status};

endmodule

### hdl/bpa_ctrl.sv
// Sequencer for the buddy page allocator: clearing pass, search, split, merge.
// Depends on bpa_pkg; drives bpa_dp through t_cmd and reads t_sts.
module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  bpa_pkg::t_sts i_sts,
    output bpa_pkg::t_cmd o_cmd
);
    import bpa_pkg::*;

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_CHK    = 5'd2;
    localparam logic [4:0] S_A_SRCH = 5'd3;
    localparam logic [4:0] S_A_U0   = 5'd4;
    localparam logic [4:0] S_A_U1   = 5'd5;
    localparam logic [4:0] S_A_SPL  = 5'd6;
    localparam logic [4:0] S_A_P0   = 5'd7;
    localparam logic [4:0] S_A_P1   = 5'd8;
    localparam logic [4:0] S_F_CHK  = 5'd9;
    localparam logic [4:0] S_F_BUD  = 5'd10;
    localparam logic [4:0] S_F_BCHK = 5'd11;
    localparam logic [4:0] S_F_U0   = 5'd12;
    localparam logic [4:0] S_F_U1   = 5'd13;
    localparam logic [4:0] S_F_MRG  = 5'd14;
    localparam logic [4:0] S_F_P0   = 5'd15;
    localparam logic [4:0] S_F_P1   = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;

    logic [4:0] r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    // next state and datapath command
    always_comb begin
        n_state         = r_state;
        o_cmd.op        = OP_NONE;
        o_cmd.res       = 1'b0;
        o_cmd.res_sts   = STS_OK;
        o_cmd.res_grant = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_sts.clr_done) begin
                    o_cmd.op = OP_NONE;
                    n_state  = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.ord_bad) begin
                    o_cmd.res     = 1'b1;
                    o_cmd.res_sts = STS_ORDER;
                    n_state       = S_DONE;
                end else if (!i_sts.cmd_free) begin
                    n_state = S_A_SRCH;
                end else if (i_sts.frm_bad) begin
                    o_cmd.res     = 1'b1;
                    o_cmd.res_sts = STS_FRAME;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.op = OP_MARK_RD;
                    n_state  = S_F_CHK;
                end
            end
            S_A_SRCH: begin
                if (!i_sts.head_empty) begin
                    o_cmd.op = OP_SEL_POP;
                    n_state  = S_A_U0;
                end else if (i_sts.cur_top) begin
                    o_cmd.res     = 1'b1;
                    o_cmd.res_sts = STS_NOFREE;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.op = OP_NEXT;
                end
            end
            S_A_U0: begin
                o_cmd.op = OP_ULNK_RD;
                n_state  = S_A_U1;
            end
            S_A_U1: begin
                o_cmd.op = OP_ULNK_WR;
                n_state  = S_A_SPL;
            end
            S_A_SPL: begin
                if (i_sts.cur_eq_ord) begin
                    o_cmd.res       = 1'b1;
                    o_cmd.res_grant = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.op = OP_SEL_SPLIT;
                    n_state  = S_A_P0;
                end
            end
            S_A_P0: begin
                if (i_sts.push_ok) begin
                    o_cmd.op = OP_PUSH0;
                    n_state  = S_A_P1;
                end else begin
                    n_state = S_A_SPL;
                end
            end
            S_A_P1: begin
                o_cmd.op = OP_PUSH1;
                n_state  = S_A_SPL;
            end
            S_F_CHK: begin
                if (i_sts.mark_q) begin
                    o_cmd.res = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_F_BUD;
                end
            end
            S_F_BUD: begin
                if (i_sts.ord_top || i_sts.bud_out) begin
                    o_cmd.op = OP_SEL_PUSHF;
                    n_state  = S_F_P0;
                end else begin
                    o_cmd.op = OP_BUD_RD;
                    n_state  = S_F_BCHK;
                end
            end
            S_F_BCHK: begin
                if (!i_sts.mark_q || !i_sts.ord_match) begin
                    o_cmd.op = OP_SEL_PUSHF;
                    n_state  = S_F_P0;
                end else begin
                    n_state = S_F_U0;
                end
            end
            S_F_U0: begin
                o_cmd.op = OP_ULNK_RD;
                n_state  = S_F_U1;
            end
            S_F_U1: begin
                o_cmd.op = OP_ULNK_WR;
                n_state  = S_F_MRG;
            end
            S_F_MRG: begin
                o_cmd.op = OP_MERGE;
                n_state  = S_F_BUD;
            end
            S_F_P0: begin
                o_cmd.op = OP_PUSH0;
                n_state  = S_F_P1;
            end
            S_F_P1: begin
                o_cmd.op  = OP_PUSH1;
                o_cmd.res = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

endmodule

### hdl/bpa_dp.sv
// Datapath of the buddy page allocator: frame memories, list heads, counters.
// Depends on bpa_pkg; steered by bpa_ctrl through t_cmd.
module bpa_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bpa_pkg::t_cmd                i_cmd,
    output bpa_pkg::t_sts                o_sts,
    input  logic [bpa_pkg::LINK_W-1:0]   i_zone,
    input  logic                         i_in_cmd,
    input  logic [bpa_pkg::ORD_W-1:0]    i_in_ord,
    input  logic [bpa_pkg::FRAME_W-1:0]  i_in_frm,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [1:0]                   o_status,
    output logic [bpa_pkg::FRAME_W-1:0]  o_grant,
    output logic [bpa_pkg::LINK_W-1:0]   o_free
);
    import bpa_pkg::*;

    // frame memories: mark bit with head order, and the two links
    logic [ORD_W:0]    r_mark_mem [NUM_FRAMES];
    logic [LINK_W-1:0] r_next_mem [NUM_FRAMES];
    logic [LINK_W-1:0] r_prev_mem [NUM_FRAMES];
    logic [ORD_W:0]    r_mark_q;
    logic [LINK_W-1:0] r_next_q, r_prev_q;

    logic [LINK_W-1:0] r_head [NUM_ORDERS];
    logic [LINK_W-1:0] r_free;
    logic [FRAME_W:0]  r_clr;

    logic              r_cmd;
    logic [ORD_W-1:0]  r_ord, r_cur, r_uo;
    logic [FRAME_W-1:0] r_frm, r_pfn, r_blk;
    logic [LINK_W-1:0] r_uf, r_h;
    logic [1:0]        r_res_sts;
    logic [FRAME_W-1:0] r_res_grant;
    logic              r_out_valid;
    logic [1:0]        r_out_sts;
    logic [FRAME_W-1:0] r_out_grant;
    logic [LINK_W-1:0] r_out_free;

    logic [FRAME_W-1:0] w_bud;
    logic [ORD_W-1:0]   w_cur_m1;
    logic [LINK_W-1:0]  w_step;

    logic              mk_we, mk_re;
    logic [FRAME_W-1:0] mk_wa, mk_ra;
    logic [ORD_W:0]    mk_wd;
    logic              nx_we, pv_we;
    logic [FRAME_W-1:0] nx_wa, pv_wa;
    logic [LINK_W-1:0] nx_wd, pv_wd;
    logic              ln_re;

    assign w_bud    = r_pfn ^ (FRAME_W'(1) << r_ord);
    assign w_cur_m1 = r_cur - ORD_W'(1);
    assign w_step   = LINK_W'(1) << r_uo;

    // status towards the sequencer
    always_comb begin
        o_sts.clr_done   = r_clr[FRAME_W];
        o_sts.head_empty = r_head[r_cur][LINK_W-1];
        o_sts.cur_top    = (r_cur == ORD_W'(NUM_ORDERS - 1));
        o_sts.cur_eq_ord = (r_cur == r_ord);
        o_sts.ord_bad    = (r_ord >= ORD_W'(NUM_ORDERS));
        o_sts.frm_bad    = ({1'b0, r_frm} >= i_zone);
        o_sts.cmd_free   = (r_cmd == CMD_FREE);
        o_sts.mark_q     = r_mark_q[ORD_W];
        o_sts.ord_match  = (r_mark_q[ORD_W-1:0] == r_ord);
        o_sts.ord_top    = (r_ord == ORD_W'(NUM_ORDERS - 1));
        o_sts.bud_out    = ({1'b0, w_bud} >= i_zone);
        o_sts.push_ok    = !r_uf[LINK_W-1];
        o_sts.out_busy   = r_out_valid && !i_m_tready;
    end

    // memory port steering
    always_comb begin
        mk_we = 1'b0; mk_wa = r_uf[FRAME_W-1:0]; mk_wd = {1'b0, r_uo};
        mk_re = 1'b0; mk_ra = r_frm;
        nx_we = 1'b0; nx_wa = r_uf[FRAME_W-1:0]; nx_wd = r_h;
        pv_we = 1'b0; pv_wa = r_uf[FRAME_W-1:0]; pv_wd = NIL_LINK;
        ln_re = 1'b0;
        case (i_cmd.op)
            OP_CLR: begin
                mk_we = 1'b1;
                mk_wa = r_clr[FRAME_W-1:0];
                mk_wd = '0;
            end
            OP_MARK_RD: begin
                mk_re = 1'b1;
            end
            OP_BUD_RD: begin
                mk_re = 1'b1;
                mk_ra = w_bud;
            end
            OP_ULNK_RD: begin
                mk_we = 1'b1;
                ln_re = 1'b1;
            end
            OP_ULNK_WR: begin
                nx_we = !r_prev_q[LINK_W-1];
                nx_wa = r_prev_q[FRAME_W-1:0];
                nx_wd = r_next_q;
                pv_we = !r_next_q[LINK_W-1];
                pv_wa = r_next_q[FRAME_W-1:0];
                pv_wd = r_prev_q;
            end
            OP_PUSH0: begin
                mk_we = 1'b1;
                mk_wd = {1'b1, r_uo};
                nx_we = 1'b1;
                nx_wd = r_head[r_uo];
                pv_we = 1'b1;
            end
            OP_PUSH1: begin
                pv_we = !r_h[LINK_W-1];
                pv_wa = r_h[FRAME_W-1:0];
                pv_wd = r_uf;
            end
            default: begin
            end
        endcase
    end

    // memories with registered reads
    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            r_mark_mem[mk_wa] <= mk_wd;
        end
        if (mk_re) begin
            r_mark_q <= r_mark_mem[mk_ra];
        end
        if (nx_we) begin
            r_next_mem[nx_wa] <= nx_wd;
        end
        if (pv_we) begin
            r_prev_mem[pv_wa] <= pv_wd;
        end
        if (ln_re) begin
            r_next_q <= r_next_mem[r_uf[FRAME_W-1:0]];
            r_prev_q <= r_prev_mem[r_uf[FRAME_W-1:0]];
        end
    end

    // list heads, free count, clearing sweep, output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ORDERS; i++) begin
                r_head[i] <= NIL_LINK;
            end
            r_free      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_CLR) begin
                r_clr <= r_clr + (FRAME_W+1)'(1);
            end
            if (i_cmd.op == OP_ULNK_WR) begin
                if (r_prev_q[LINK_W-1]) begin
                    r_head[r_uo] <= r_next_q;
                end
                r_free <= r_free - w_step;
            end
            if (i_cmd.op == OP_PUSH0) begin
                r_head[r_uo] <= r_uf;
                r_free       <= r_free + w_step;
            end
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers of the current word
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cmd <= i_in_cmd;
                r_ord <= i_in_ord;
                r_cur <= i_in_ord;
                r_frm <= i_in_frm;
                r_pfn <= i_in_frm;
            end
            OP_NEXT: begin
                r_cur <= r_cur + ORD_W'(1);
            end
            OP_SEL_POP: begin
                r_blk <= r_head[r_cur][FRAME_W-1:0];
                r_uf  <= r_head[r_cur];
                r_uo  <= r_cur;
            end
            OP_SEL_SPLIT: begin
                r_cur <= w_cur_m1;
                r_uo  <= w_cur_m1;
                r_uf  <= {1'b0, r_blk} + (LINK_W'(1) << w_cur_m1);
            end
            OP_SEL_PUSHF: begin
                r_uf <= {1'b0, r_pfn};
                r_uo <= r_ord;
            end
            OP_BUD_RD: begin
                r_uf <= {1'b0, w_bud};
                r_uo <= r_ord;
            end
            OP_MERGE: begin
                r_pfn <= r_pfn & r_uf[FRAME_W-1:0];
                r_ord <= r_ord + ORD_W'(1);
            end
            OP_PUSH0: begin
                r_h <= r_head[r_uo];
            end
            OP_OUT: begin
                r_out_sts   <= r_res_sts;
                r_out_grant <= r_res_grant;
                r_out_free  <= r_free;
            end
            default: begin
            end
        endcase
        if (i_cmd.res) begin
            r_res_sts   <= i_cmd.res_sts;
            r_res_grant <= i_cmd.res_grant ? r_blk : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_status   = r_out_sts;
    assign o_grant    = r_out_grant;
    assign o_free     = r_out_free;

`ifndef SYNTHESIS
    a_free_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op != OP_PUSH0 && i_cmd.op != OP_ULNK_WR) |=> $stable(r_free))
        else $error("free count moved without a list update");
    a_clr_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr[FRAME_W] |-> (i_cmd.op == OP_CLR || i_cmd.op == OP_NONE))
        else $error("operation issued during clearing sweep");
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sts != STS_OK) |-> (r_out_grant == '0))
        else $error("granted frame set on a failed word");
`endif

endmodule
